@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Node kinds, result status codes and sequencer states shared by the design.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int ADDR_OUT_W = 10;
    localparam int REQ_W      = 11;
    localparam int OWNER_W    = 16;

    typedef enum logic [1:0] {
        KIND_UNUSED = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_SPLIT  = 2'd2,
        KIND_ALLOC  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_VISIT_RD,
        S_VISIT_EV,
        S_ADVANCE,
        S_SPLIT_CHK,
        S_SPLIT_W1,
        S_SPLIT_W2,
        S_ALLOC_W,
        S_FREE_W,
        S_MERGE_UP,
        S_MERGE_RDL,
        S_MERGE_RDR,
        S_MERGE_CHK,
        S_MERGE_WL,
        S_MERGE_WR,
        S_MERGE_WN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic kind_we;
        logic owner_we;
    } mem_ctl_t;

endpackage

@@ rtl/bba_node_ram.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator node store
// Single-port memories for node kind and node owner with registered reads.
// ----------------------------------------------------------------------------
module bba_node_ram #(
    parameter int NODE_W     = 11,
    parameter int NODE_COUNT = 2047
) (
    input  logic                         aclk,
    input  logic [NODE_W-1:0]            mem_addr,
    input  bba_pkg::mem_ctl_t            mem_ctl,
    input  bba_pkg::kind_t               kind_wdata,
    input  logic [bba_pkg::OWNER_W-1:0]  owner_wdata,
    output bba_pkg::kind_t               kind_rdata,
    output logic [bba_pkg::OWNER_W-1:0]  owner_rdata
);
    import bba_pkg::*;

    logic [1:0]         kind_mem  [0:NODE_COUNT-1];
    logic [OWNER_W-1:0] owner_mem [0:NODE_COUNT-1];
    logic [1:0]         kind_rd_reg;
    logic [OWNER_W-1:0] owner_rd_reg;

    always_ff @(posedge aclk) begin
        if (mem_ctl.kind_we) begin
            kind_mem[mem_addr] <= kind_wdata;
        end
        kind_rd_reg <= kind_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (mem_ctl.owner_we) begin
            owner_mem[mem_addr] <= owner_wdata;
        end
        owner_rd_reg <= owner_mem[mem_addr];
    end

    assign kind_rdata  = kind_t'(kind_rd_reg);
    assign owner_rdata = owner_rd_reg;

endmodule

@@ rtl/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator sequencer
// Walks the block tree one node at a time, splits, allocates, frees and merges.
// ----------------------------------------------------------------------------
module bba_ctrl #(
    parameter int MEM_SIZE = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic [bba_pkg::OWNER_W-1:0]        s_owner_id,
    input  logic [bba_pkg::REQ_W-1:0]          s_request_size,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic [bba_pkg::ADDR_OUT_W-1:0]     m_block_address,
    output logic [$clog2(MEM_SIZE):0]          mem_addr,
    output bba_pkg::mem_ctl_t                  mem_ctl,
    output bba_pkg::kind_t                     kind_wdata,
    output logic [bba_pkg::OWNER_W-1:0]        owner_wdata,
    input  bba_pkg::kind_t                     kind_rdata,
    input  logic [bba_pkg::OWNER_W-1:0]        owner_rdata
);
    import bba_pkg::*;

    localparam int LOG2       = $clog2(MEM_SIZE);
    localparam int NODE_W     = LOG2 + 1;
    localparam int NODE_COUNT = 2 * MEM_SIZE - 1;
    localparam int DEPTH_W    = $clog2(LOG2 + 1);
    localparam int SIZE_W     = LOG2 + 1;
    localparam int CMP_W      = (SIZE_W > REQ_W) ? SIZE_W : REQ_W;
    localparam int WIDE_W     = (NODE_W > ADDR_OUT_W) ? NODE_W : ADDR_OUT_W;

    state_t                state_reg, state_next;
    logic [NODE_W-1:0]     n_reg, n_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic                  cmd_reg, cmd_next;
    logic [OWNER_W-1:0]    owner_reg, owner_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic                  lfree_reg, lfree_next;
    status_t               res_status_reg, res_status_next;
    logic [ADDR_OUT_W-1:0] res_addr_reg, res_addr_next;
    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            m_status_reg, m_status_next;
    logic [ADDR_OUT_W-1:0] m_addr_reg, m_addr_next;

    logic [NODE_W-1:0]     left_node;
    logic [NODE_W-1:0]     right_node;
    logic [NODE_W-1:0]     parent_node;
    logic [SIZE_W-1:0]     half_size;
    logic                  size_ge;
    logic                  half_ge;
    logic                  at_bottom;
    logic                  descend_ok;
    logic                  owner_hit;
    logic                  clear_last;
    logic                  out_free;
    logic [NODE_W-1:0]     node_off;
    logic [DEPTH_W-1:0]    shamt;
    logic [WIDE_W-1:0]     addr_wide;

    assign left_node   = {n_reg[NODE_W-2:0], 1'b1};
    assign right_node  = NODE_W'({n_reg[NODE_W-2:0], 1'b1} + 1'b1);
    assign parent_node = NODE_W'((n_reg - 1'b1) >> 1);
    assign half_size   = size_reg >> 1;
    assign size_ge     = CMP_W'(size_reg) >= CMP_W'(req_reg);
    assign half_ge     = CMP_W'(half_size) >= CMP_W'(req_reg);
    assign at_bottom   = depth_reg == DEPTH_W'(LOG2);
    assign descend_ok  = (kind_rdata == KIND_SPLIT) && half_ge && !at_bottom;
    assign owner_hit   = (kind_rdata == KIND_ALLOC) && (owner_rdata == owner_reg);
    assign clear_last  = n_reg == NODE_W'(NODE_COUNT - 1);
    assign out_free    = !m_valid_reg || m_ready;
    assign node_off    = NODE_W'(n_reg + 1'b1) - (NODE_W'(1) << depth_reg);
    assign shamt       = DEPTH_W'(LOG2) - depth_reg;
    assign addr_wide   = WIDE_W'(node_off) << shamt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        depth_reg      <= depth_next;
        size_reg       <= size_next;
        cmd_reg        <= cmd_next;
        owner_reg      <= owner_next;
        req_reg        <= req_next;
        lfree_reg      <= lfree_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (!s_command && s_request_size == '0) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_VISIT_RD;
                    end
                end
            end
            S_VISIT_RD: state_next = S_VISIT_EV;
            S_VISIT_EV: begin
                if (!cmd_reg && kind_rdata == KIND_FREE && size_ge) begin
                    state_next = S_SPLIT_CHK;
                end else if (cmd_reg && owner_hit) begin
                    state_next = S_FREE_W;
                end else if (descend_ok) begin
                    state_next = S_VISIT_RD;
                end else begin
                    state_next = S_ADVANCE;
                end
            end
            S_ADVANCE: begin
                if (n_reg == '0) begin
                    state_next = S_FINISH;
                end else if (n_reg[0]) begin
                    state_next = S_VISIT_RD;
                end
            end
            S_SPLIT_CHK: begin
                if (half_ge && !at_bottom) begin
                    state_next = S_SPLIT_W1;
                end else begin
                    state_next = S_ALLOC_W;
                end
            end
            S_SPLIT_W1:  state_next = S_SPLIT_W2;
            S_SPLIT_W2:  state_next = S_SPLIT_CHK;
            S_ALLOC_W:   state_next = S_FINISH;
            S_FREE_W: begin
                state_next = (n_reg == '0) ? S_FINISH : S_MERGE_UP;
            end
            S_MERGE_UP:  state_next = S_MERGE_RDL;
            S_MERGE_RDL: state_next = S_MERGE_RDR;
            S_MERGE_RDR: state_next = S_MERGE_CHK;
            S_MERGE_CHK: begin
                if (lfree_reg && kind_rdata == KIND_FREE) begin
                    state_next = S_MERGE_WL;
                end else begin
                    state_next = (n_reg == '0) ? S_FINISH : S_MERGE_UP;
                end
            end
            S_MERGE_WL:  state_next = S_MERGE_WR;
            S_MERGE_WR:  state_next = S_MERGE_WN;
            S_MERGE_WN: begin
                state_next = (n_reg == '0) ? S_FINISH : S_MERGE_UP;
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        n_next          = n_reg;
        depth_next      = depth_reg;
        size_next       = size_reg;
        cmd_next        = cmd_reg;
        owner_next      = owner_reg;
        req_next        = req_reg;
        lfree_next      = lfree_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        case (state_reg)
            S_CLEAR: begin
                if (!clear_last) begin
                    n_next = n_reg + 1'b1;
                end
            end
            S_IDLE: begin
                n_next          = '0;
                depth_next      = '0;
                size_next       = SIZE_W'(MEM_SIZE);
                cmd_next        = s_command;
                owner_next      = s_owner_id;
                req_next        = s_request_size;
                res_status_next = ST_NO_FIT;
                res_addr_next   = '0;
            end
            S_VISIT_EV: begin
                if (!(!cmd_reg && kind_rdata == KIND_FREE && size_ge) &&
                    !(cmd_reg && owner_hit) && descend_ok) begin
                    n_next     = left_node;
                    depth_next = depth_reg + 1'b1;
                    size_next  = half_size;
                end
            end
            S_ADVANCE: begin
                if (n_reg == '0) begin
                    res_status_next = cmd_reg ? ST_NOT_FOUND : ST_NO_FIT;
                    res_addr_next   = '0;
                end else if (n_reg[0]) begin
                    n_next = n_reg + 1'b1;
                end else begin
                    n_next     = parent_node;
                    depth_next = depth_reg - 1'b1;
                    size_next  = size_reg << 1;
                end
            end
            S_SPLIT_W2: begin
                n_next     = left_node;
                depth_next = depth_reg + 1'b1;
                size_next  = half_size;
            end
            S_ALLOC_W, S_FREE_W: begin
                res_status_next = ST_DONE;
                res_addr_next   = addr_wide[ADDR_OUT_W-1:0];
            end
            S_MERGE_UP: begin
                n_next = parent_node;
            end
            S_MERGE_RDR: begin
                lfree_next = kind_rdata == KIND_FREE;
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mem_addr         = n_reg;
        mem_ctl.kind_we  = 1'b0;
        mem_ctl.owner_we = 1'b0;
        kind_wdata       = KIND_UNUSED;
        owner_wdata      = owner_reg;
        unique case (state_reg)
            S_CLEAR: begin
                mem_ctl.kind_we = 1'b1;
                kind_wdata      = (n_reg == '0) ? KIND_FREE : KIND_UNUSED;
            end
            S_SPLIT_W1: begin
                mem_ctl.kind_we = 1'b1;
                kind_wdata      = KIND_SPLIT;
            end
            S_SPLIT_W2: begin
                mem_addr        = right_node;
                mem_ctl.kind_we = 1'b1;
                kind_wdata      = KIND_FREE;
            end
            S_ALLOC_W: begin
                mem_ctl.kind_we  = 1'b1;
                mem_ctl.owner_we = 1'b1;
                kind_wdata       = KIND_ALLOC;
            end
            S_FREE_W, S_MERGE_WN: begin
                mem_ctl.kind_we = 1'b1;
                kind_wdata      = KIND_FREE;
            end
            S_MERGE_RDL: mem_addr = left_node;
            S_MERGE_RDR: mem_addr = right_node;
            S_MERGE_WL: begin
                mem_addr        = left_node;
                mem_ctl.kind_we = 1'b1;
            end
            S_MERGE_WR: begin
                mem_addr        = right_node;
                mem_ctl.kind_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign s_ready         = state_reg == S_IDLE;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_block_address = m_addr_reg;

endmodule

@@ rtl/buddy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates and frees power-of-two blocks kept in a binary tree of nodes.
// ----------------------------------------------------------------------------
// A word visits tree nodes, reading each one and backtracking as needed, then
// either splits level by level and allocates, or frees the owned block and checks
// each ancestor, merging two free children into it; the result word follows, and
// a zero-size allocation answers without visiting the tree. One word is in work at a time.
// After reset the node memory is cleared with s_ready low.
module buddy_block_allocator #(
    parameter int MEM_SIZE = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [bba_pkg::OWNER_W-1:0]     s_owner_id,
    input  logic [bba_pkg::REQ_W-1:0]       s_request_size,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [bba_pkg::ADDR_OUT_W-1:0]  m_block_address
);
    import bba_pkg::*;

    localparam int NODE_W     = $clog2(MEM_SIZE) + 1;
    localparam int NODE_COUNT = 2 * MEM_SIZE - 1;

    logic [NODE_W-1:0]  mem_addr;
    mem_ctl_t           mem_ctl;
    kind_t              kind_wdata;
    kind_t              kind_rdata;
    logic [OWNER_W-1:0] owner_wdata;
    logic [OWNER_W-1:0] owner_rdata;

    bba_ctrl #(
        .MEM_SIZE (MEM_SIZE)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_owner_id      (s_owner_id),
        .s_request_size  (s_request_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_block_address (m_block_address),
        .mem_addr        (mem_addr),
        .mem_ctl         (mem_ctl),
        .kind_wdata      (kind_wdata),
        .owner_wdata     (owner_wdata),
        .kind_rdata      (kind_rdata),
        .owner_rdata     (owner_rdata)
    );

    bba_node_ram #(
        .NODE_W     (NODE_W),
        .NODE_COUNT (NODE_COUNT)
    ) u_ram (
        .aclk        (aclk),
        .mem_addr    (mem_addr),
        .mem_ctl     (mem_ctl),
        .kind_wdata  (kind_wdata),
        .owner_wdata (owner_wdata),
        .kind_rdata  (kind_rdata),
        .owner_rdata (owner_rdata)
    );

endmodule

@@ verif/buddy_block_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free words with random idling on both channels, keeps
// its own copy of the block tree to predict every status and address, and
// compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module buddy_block_allocator_tb;
    import bba_pkg::*;

    localparam int MEM       = 1024;
    localparam int NODES     = 2 * MEM - 1;
    localparam int N_RANDOM  = 1400;
    localparam int LIMIT     = 40000000;
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct {
        logic                cmd;
        logic [OWNER_W-1:0]  owner;
        logic [REQ_W-1:0]    size;
    } request_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_command = 1'b0;
    logic [OWNER_W-1:0]     s_owner_id = '0;
    logic [REQ_W-1:0]       s_request_size = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_status;
    logic [ADDR_OUT_W-1:0]  m_block_address;

    request_t               pending_requests[$];
    status_t                expected_status[$];
    logic [ADDR_OUT_W-1:0]  expected_address[$];
    kind_t                  tree_kind[NODES];
    logic [OWNER_W-1:0]     tree_owner[NODES];
    logic                   took = 1'b0;
    int                     cycles = 0;
    int                     mismatches = 0;

    buddy_block_allocator #(.MEM_SIZE(MEM)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_owner_id(s_owner_id), .s_request_size(s_request_size),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_block_address(m_block_address)
    );

    always #5 aclk = ~aclk;

    function automatic int node_depth(int n);
        int d;
        d = 0;
        while (((n + 1) >> (d + 1)) != 0) d++;
        return d;
    endfunction

    function automatic int node_address(int n);
        int d;
        d = node_depth(n);
        return ((n + 1) - (1 << d)) * (MEM >> d);
    endfunction

    function automatic int lowest_free_leaf(int n, int sz, int req);
        int r;
        if (n >= NODES) return -1;
        if (tree_kind[n] == KIND_FREE) return (sz >= req) ? n : -1;
        if (tree_kind[n] == KIND_SPLIT && sz / 2 >= req) begin
            r = lowest_free_leaf(2 * n + 1, sz / 2, req);
            if (r >= 0) return r;
            return lowest_free_leaf(2 * n + 2, sz / 2, req);
        end
        return -1;
    endfunction

    function automatic int owned_block(int n, int sz, int req, logic [OWNER_W-1:0] who);
        int r;
        if (n >= NODES) return -1;
        if (tree_kind[n] == KIND_ALLOC && tree_owner[n] == who) return n;
        if (tree_kind[n] == KIND_SPLIT && sz / 2 >= req) begin
            r = owned_block(2 * n + 1, sz / 2, req, who);
            if (r >= 0) return r;
            return owned_block(2 * n + 2, sz / 2, req, who);
        end
        return -1;
    endfunction

    task automatic serve_request(input request_t rq);
        int n;
        int sz;
        int req;
        status_t st;
        int addr;
        req = rq.size;
        addr = 0;
        if (rq.cmd == CMD_ALLOC) begin
            n = (req == 0) ? -1 : lowest_free_leaf(0, MEM, req);
            if (n < 0) begin
                st = ST_NO_FIT;
            end else begin
                sz = MEM >> node_depth(n);
                while (sz / 2 >= req && 2 * n + 2 < NODES) begin
                    tree_kind[n] = KIND_SPLIT;
                    tree_kind[2 * n + 1] = KIND_FREE;
                    tree_kind[2 * n + 2] = KIND_FREE;
                    n = 2 * n + 1;
                    sz = sz / 2;
                end
                tree_kind[n] = KIND_ALLOC;
                tree_owner[n] = rq.owner;
                addr = node_address(n);
                st = ST_DONE;
            end
        end else begin
            n = owned_block(0, MEM, req, rq.owner);
            if (n < 0) begin
                st = ST_NOT_FOUND;
            end else begin
                addr = node_address(n);
                tree_kind[n] = KIND_FREE;
                while (n > 0) begin
                    n = (n - 1) / 2;
                    if (tree_kind[2 * n + 1] == KIND_FREE && tree_kind[2 * n + 2] == KIND_FREE) begin
                        tree_kind[2 * n + 1] = KIND_UNUSED;
                        tree_kind[2 * n + 2] = KIND_UNUSED;
                        tree_kind[n] = KIND_FREE;
                    end
                end
                st = ST_DONE;
            end
        end
        expected_status.push_back(st);
        expected_address.push_back(addr[ADDR_OUT_W-1:0]);
    endtask

    function automatic logic idle_now();
        if (cycles > 30000 && cycles < 60000) return 1'b0;
        return $urandom_range(0, 99) < 17;
    endfunction

    // Driver: new words go out on the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || took) begin
                if (pending_requests.size() > 0 && !idle_now()) begin
                    s_command <= pending_requests[0].cmd;
                    s_owner_id <= pending_requests[0].owner;
                    s_request_size <= pending_requests[0].size;
                    s_valid <= 1'b1;
                    void'(pending_requests.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !idle_now();
        end
    end

    // Prediction and result checking at the rising edge.
    always @(posedge aclk) begin
        request_t rq;
        cycles <= cycles + 1;
        took <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            rq.cmd = s_command;
            rq.owner = s_owner_id;
            rq.size = s_request_size;
            serve_request(rq);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: status %0d address %0d",
                             m_status, m_block_address);
            end else begin
                if (m_status !== expected_status[0] ||
                    m_block_address !== expected_address[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected status %0d address %0d, got %0d %0d",
                                 expected_status[0], expected_address[0],
                                 m_status, m_block_address);
                end
                void'(expected_status.pop_front());
                void'(expected_address.pop_front());
            end
        end
        if (cycles >= LIMIT) begin
            $display("buddy_block_allocator verification failed");
            $finish;
        end
    end

    task automatic queue_request(input logic cmd, input int who, input int sz);
        request_t rq;
        rq.cmd = cmd;
        rq.owner = who[OWNER_W-1:0];
        rq.size = sz[REQ_W-1:0];
        pending_requests.push_back(rq);
    endtask

    initial begin
        int live_owner[$];
        int live_size[$];
        int r;
        int e;
        int sz;
        int who;
        int idx;
        foreach (tree_kind[i]) begin
            tree_kind[i] = KIND_UNUSED;
            tree_owner[i] = '0;
        end
        tree_kind[0] = KIND_FREE;

        queue_request(CMD_ALLOC, 1, 0);
        queue_request(CMD_ALLOC, 1, 1025);
        queue_request(CMD_ALLOC, 2, 2047);
        queue_request(CMD_ALLOC, 16'hFFFF, 1024);
        queue_request(CMD_ALLOC, 3, 1);
        queue_request(CMD_FREE, 16'hFFFF, 2047);
        queue_request(CMD_FREE, 16'hFFFF, 1024);
        queue_request(CMD_FREE, 16'hFFFF, 0);
        queue_request(CMD_ALLOC, 0, 1);
        queue_request(CMD_ALLOC, 16'hFFFF, 3);
        queue_request(CMD_ALLOC, 4, 512);
        queue_request(CMD_ALLOC, 5, 256);
        queue_request(CMD_ALLOC, 6, 129);
        queue_request(CMD_ALLOC, 7, 64);
        queue_request(CMD_ALLOC, 8, 64);
        queue_request(CMD_ALLOC, 9, 1);
        queue_request(CMD_FREE, 1234, 1);
        queue_request(CMD_FREE, 0, 1024);
        queue_request(CMD_FREE, 0, 1);
        queue_request(CMD_FREE, 4, 512);
        queue_request(CMD_FREE, 5, 1);
        queue_request(CMD_FREE, 16'hFFFF, 4);
        queue_request(CMD_FREE, 6, 100);
        queue_request(CMD_FREE, 7, 64);
        queue_request(CMD_FREE, 8, 64);

        for (int k = 0; k < N_RANDOM; k++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                queue_request(logic'($urandom_range(0, 1)), $urandom_range(0, 65535),
                              $urandom_range(0, 2047));
            end else if (r < 55 || live_owner.size() == 0) begin
                e = $urandom_range(0, $urandom_range(0, 10));
                sz = $urandom_range(1, 1 << e);
                who = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(1, 40);
                queue_request(CMD_ALLOC, who, sz);
                live_owner.push_back(who);
                live_size.push_back(sz);
            end else begin
                idx = $urandom_range(0, live_owner.size() - 1);
                queue_request(CMD_FREE, live_owner[idx], $urandom_range(0, live_size[idx]));
                live_owner.delete(idx);
                live_size.delete(idx);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_requests.size() == 0 && !s_valid && expected_status.size() == 0);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("buddy_block_allocator verification clean");
        end else begin
            $display("buddy_block_allocator verification failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/bba_pkg.sv
rtl/bba_node_ram.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator.sv
verif/buddy_block_allocator_tb.sv
